// ===== design/aes_pkg.sv =====
// AES package: S-box functions, round helpers, command type.
// Used by aes_ctrl, aes_datapath, aes_block_cipher and the testbench.
package aes_pkg;

  localparam int KeyWordDepth = 60;

  localparam logic [2:0] CfgKeySize = 3'd0;
  localparam logic [2:0] CfgKey0    = 3'd1;
  localparam logic [2:0] CfgKey3    = 3'd4;

  localparam logic [1:0] Key128 = 2'd0;
  localparam logic [1:0] Key192 = 2'd1;
  localparam logic [1:0] Key256 = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load_key;   // copy key registers into the word window
    logic       exp_step;   // compute and store one schedule word
    logic       load_blk;   // load input block
    logic       first_rnd;  // initial key addition
    logic       mid_rnd;    // full round
    logic       last_rnd;   // final round (no mix)
    logic       decrypt;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // forward MixColumns on one column, byte 0 in the top bits
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse MixColumns: pre-multiply by {05,00,04,00} then forward mix
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/aes_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/aes_datapath.sv =====
// AES datapath: key window for expansion, round-key RAM, state register.
// Depends on aes_pkg and aes_ram.
module aes_datapath #(
  parameter int KeyWordDepth = aes_pkg::KeyWordDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aes_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(KeyWordDepth)-1:0] addr_i,   // RAM word address
  input  logic                            wr_i,     // store the new schedule word
  input  logic [3:0]                      nk_i,     // key words: 4, 6 or 8
  input  logic [2:0]                      pos_i,    // i mod nk
  input  logic [3:0]                      rc_i,     // i / nk
  input  logic [1:0]                      col_i,    // column of the round key
  input  logic                            key_ok_i, // address inside the RAM
  input  logic [255:0]                    key_i,
  input  logic [63:0]                     blk_hi_i,
  input  logic [63:0]                     blk_lo_i,
  output logic [127:0]                    state_o
);

  localparam int AW = $clog2(KeyWordDepth);

  // window of the last eight schedule words, newest at w[0]
  logic [31:0] win_q [8];
  logic [31:0] new_w, prev, temp, far;
  logic [31:0] rdata;
  logic [127:0] state_q, state_d, rk_q;
  logic [127:0] sb, sr, mx;

  // next schedule word
  always_comb begin
    prev = win_q[0];
    unique case (nk_i)
      4'd4:    far = win_q[3];
      4'd6:    far = win_q[5];
      default: far = win_q[7];
    endcase
    if (pos_i == 3'd0) begin
      temp = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {aes_pkg::rcon(rc_i), 24'h0};
    end else if (nk_i == 4'd8 && pos_i == 3'd4) begin
      temp = aes_pkg::sub_word(prev);
    end else begin
      temp = prev;
    end
    new_w = far ^ temp;
  end

  // raw key word selected by the load address, word 0 at bit 255
  logic [31:0] raw_w;
  assign raw_w = key_i[255 - 32*addr_i[2:0] -: 32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key || cmd_i.exp_step) begin
      win_q[0] <= cmd_i.load_key ? raw_w : new_w;
      for (int k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // the first nk words come straight from the key
  logic [31:0] wdata;
  assign wdata = (cmd_i.load_key) ? raw_w : new_w;

  aes_ram #(.Width(32), .Depth(KeyWordDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i),
    .addr_i  (addr_i[AW-1:0]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // assemble the 128-bit round key one column per cycle
  always_ff @(posedge clk_i) begin
    rk_q[127 - 32*col_i -: 32] <= key_ok_i ? rdata : 32'h0;
  end

  // round logic
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = cmd_i.decrypt ? aes_pkg::inv_sub_byte(sr[127-8*i -: 8])
                                       : aes_pkg::sbox(state_q[127-8*i -: 8]);
    end
  end

  logic [127:0] src;
  assign src = state_q;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(r+4*c) -: 8] = cmd_i.decrypt ?
          src[127-8*(r+4*((c-r+4)%4)) -: 8] : 8'h0;
      end
    end
  end

  logic [127:0] shf, ark;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    mx = '0;
    ark = '0;
    if (cmd_i.load_blk) begin
      state_d = {blk_hi_i, blk_lo_i};
    end else if (cmd_i.first_rnd) begin
      state_d = state_q ^ rk_q;
    end else if (cmd_i.mid_rnd || cmd_i.last_rnd) begin
      if (!cmd_i.decrypt) begin
        for (int c = 0; c < 4; c++) begin
          mx[127-32*c -: 32] = aes_pkg::mix_col(shf[127-32*c -: 32]);
        end
        state_d = (cmd_i.last_rnd ? shf : mx) ^ rk_q;
      end else begin
        ark = sb ^ rk_q;
        for (int c = 0; c < 4; c++) begin
          mx[127-32*c -: 32] = aes_pkg::inv_mix_col(ark[127-32*c -: 32]);
        end
        state_d = cmd_i.last_rnd ? ark : mx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== design/aes_ctrl.sv =====
// AES controller: key expansion sequencer and round sequencer.
// Depends on aes_pkg.
module aes_ctrl #(
  parameter int KeyWordDepth = aes_pkg::KeyWordDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            kind_i,
  input  logic                            stale_i,
  input  logic [1:0]                      key_size_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic                            clr_stale_o,
  output aes_pkg::cmd_t                   cmd_o,
  output logic [$clog2(KeyWordDepth)-1:0] addr_o,
  output logic                            wr_o,
  output logic [3:0]                      nk_o,
  output logic [2:0]                      pos_o,
  output logic [3:0]                      rc_o,
  output logic [1:0]                      col_o,
  output logic                            key_ok_o,
  output logic                            load_key_o
);

  localparam int AW = $clog2(KeyWordDepth);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoadK = 3'd1; // store raw key words
  localparam logic [2:0] StExp   = 3'd2; // one schedule word a cycle
  localparam logic [2:0] StFetch = 3'd3; // read four words of a round key
  localparam logic [2:0] StRound = 3'd4; // apply round
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [5:0] wi_q, wi_d;     // schedule word index
  logic [2:0] pos_q, pos_d;
  logic [3:0] rc_q, rc_d;
  logic [3:0] rnd_q, rnd_d;   // rounds applied
  logic [2:0] fc_q, fc_d;     // fetch count 0..4 (the extra step covers the registered RAM read)
  logic       dec_q, dec_d;
  logic [3:0] nr_q, nr_d;
  logic [3:0] nk_q, nk_d;
  logic [1:0] sel;
  logic [3:0] kidx;           // round key number being fetched
  logic [5:0] raddr;
  logic [1:0] col_q;
  logic       ok_q;

  // requested key size, reduced to the largest whose schedule fits the RAM
  always_comb begin
    sel = (key_size_i == 2'd3) ? aes_pkg::Key256 : key_size_i;
    if (sel == aes_pkg::Key256 && KeyWordDepth < 60) sel = aes_pkg::Key192;
    if (sel == aes_pkg::Key192 && KeyWordDepth < 52) sel = aes_pkg::Key128;
  end

  assign kidx  = dec_q ? nr_q - rnd_q : rnd_q;
  assign raddr = {kidx, 2'b00} + {4'd0, fc_q[1:0]};

  always_comb begin
    st_d = st_q; wi_d = wi_q; pos_d = pos_q; rc_d = rc_q;
    rnd_d = rnd_q; fc_d = fc_q; dec_d = dec_q; nr_d = nr_q; nk_d = nk_q;
    clr_stale_o = 1'b0;
    cmd_o = '0;
    cmd_o.decrypt = dec_q;
    wr_o = 1'b0;
    addr_o = raddr[AW-1:0];
    load_key_o = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          dec_d = kind_i;
          rnd_d = 4'd0;
          fc_d  = 3'd0;
          cmd_o.load_blk = 1'b1;
          if (stale_i) begin
            nk_d = 4'd4 + {1'b0, sel, 1'b0};
            nr_d = 4'd10 + {1'b0, sel, 1'b0};
            wi_d = 6'd0;
            st_d = StLoadK;
          end else begin
            st_d = StFetch;
          end
        end
      end
      StLoadK: begin
        // shift raw key words into the window and the RAM
        load_key_o = 1'b1;
        cmd_o.load_key = 1'b1;
        wr_o = 1'b1;
        addr_o = wi_q[AW-1:0];
        wi_d = wi_q + 6'd1;
        if (wi_q + 6'd1 == {2'd0, nk_q}) begin
          pos_d = 3'd0;
          rc_d = 4'd1;
          st_d = StExp;
        end
      end
      StExp: begin
        cmd_o.exp_step = 1'b1;
        wr_o = ({1'b0, wi_q} < 7'(KeyWordDepth));
        addr_o = wi_q[AW-1:0];
        wi_d = wi_q + 6'd1;
        if ({1'b0, pos_q} + 4'd1 == nk_q) begin
          pos_d = 3'd0;
          rc_d = rc_q + 4'd1;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        if (wi_q + 6'd1 == {nr_q, 2'b00} + 6'd4) begin
          clr_stale_o = 1'b1;
          st_d = StFetch;
        end
      end
      StFetch: begin
        fc_d = fc_q + 3'd1;
        if (fc_q == 3'd4) begin
          fc_d = 3'd0;
          st_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == 4'd0) cmd_o.first_rnd = 1'b1;
        else if (rnd_q == nr_q) cmd_o.last_rnd = 1'b1;
        else cmd_o.mid_rnd = 1'b1;
        rnd_d = rnd_q + 4'd1;
        st_d = (rnd_q == nr_q) ? StDone : StFetch;
      end
      StDone: begin
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // round key column tracking follows the RAM read latency
  always_ff @(posedge clk_i) begin
    col_q <= fc_q[1:0];
    ok_q  <= ({1'b0, raddr} < 7'(KeyWordDepth));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; wi_q <= '0; pos_q <= '0; rc_q <= '0; rnd_q <= '0;
      fc_q <= '0; dec_q <= 1'b0; nr_q <= 4'd10; nk_q <= 4'd4;
    end else begin
      st_q <= st_d; wi_q <= wi_d; pos_q <= pos_d; rc_q <= rc_d; rnd_q <= rnd_d;
      fc_q <= fc_d; dec_q <= dec_d; nr_q <= nr_d; nk_q <= nk_d;
    end
  end

  assign busy_o = (st_q != StIdle);
  assign done_o = (st_q == StDone);
  assign nk_o   = nk_q;
  assign pos_o  = pos_q;
  assign rc_o   = rc_q;
  // column index is the fetch count registered, matching the RAM read data
  assign col_o    = col_q;
  assign key_ok_o = ok_q;

`ifndef SYNTHESIS
  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDone) |-> $past(st_q) == StRound) else $error("done without round");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && st_q != StDone) |=> busy_o) else $error("dropped busy mid-block");
  a_rounds_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRound) |-> rnd_q <= nr_q) else $error("round count overrun");
`endif

endmodule

// ===== design/aes_block_cipher.sv =====
// AES-128/192/256 block cipher top level: config registers, glue.
// Depends on aes_pkg, aes_ctrl, aes_datapath.
//
// channel | direction | handshake          | payload
// config  | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
// block   | in        | start_i & !busy_o  | kind_i, block_high_i, block_low_i
// result  | out       | done_o strobe      | result_high_o, result_low_o
//
// Each round fetches the four round-key words from RAM (registered read data),
// then applies the round; done_o follows the last round, and busy_o stays
// high through done_o, so the next block is taken only after the current one.
// After reset or a key or key size write, the next block first runs the key
// schedule: Nk key words loaded, then one word per cycle (44 to 60 words total).
// done_o is high for one cycle; the receiver cannot stall.
module aes_block_cipher #(
  parameter int KeyWordDepth = aes_pkg::KeyWordDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        done_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  localparam int AW = $clog2(KeyWordDepth);

  logic [1:0]   ksize_q;
  logic [255:0] key_q;
  logic         stale_q, clr_stale;
  aes_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  logic wr, key_ok, load_key;
  logic [3:0] nk;
  logic [2:0] pos;
  logic [3:0] rc;
  logic [1:0] col;
  logic [127:0] st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= '0; key_q <= '0; stale_q <= 1'b1;
    end else begin
      if (clr_stale) stale_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == aes_pkg::CfgKeySize) begin
          ksize_q <= cfg_data_i[1:0]; stale_q <= 1'b1;
        end else if (cfg_idx_i >= aes_pkg::CfgKey0 && cfg_idx_i <= aes_pkg::CfgKey3) begin
          key_q[255 - 64*(cfg_idx_i - aes_pkg::CfgKey0) -: 64] <= cfg_data_i;
          stale_q <= 1'b1;
        end
      end
    end
  end

  aes_ctrl #(.KeyWordDepth(KeyWordDepth)) u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i,
    .stale_i (stale_q), .key_size_i (ksize_q),
    .busy_o, .done_o, .clr_stale_o (clr_stale),
    .cmd_o (cmd), .addr_o (addr), .wr_o (wr), .nk_o (nk), .pos_o (pos),
    .rc_o (rc), .col_o (col), .key_ok_o (key_ok), .load_key_o (load_key)
  );

  // key load picks one raw word per cycle by the RAM address
  aes_datapath #(.KeyWordDepth(KeyWordDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .addr_i (addr), .wr_i (wr),
    .nk_i (nk), .pos_i (pos), .rc_i (rc), .col_i (col), .key_ok_i (key_ok),
    .key_i (key_q),
    .blk_hi_i (block_high_i), .blk_lo_i (block_low_i), .state_o (st)
  );

  assign result_high_o = st[127:64];
  assign result_low_o  = st[63:0];

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_key |-> busy_o) else $error("load idle");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for aes_block_cipher: AES-128/192/256 encrypt and decrypt.
// Depends on aes_pkg for config indexes and key size codes; predicts in its own functions.
`timescale 1ns / 1ps

module tb;

  localparam int WatchLimit = 5000;

  typedef enum logic {OpEncrypt = 1'b0, OpDecrypt = 1'b1} op_e;

  typedef struct {
    op_e         op;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } ct_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        kind_i = 1'b0;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        done_o;
  logic [63:0] result_high_o, result_low_o;

  aes_block_cipher dut (.*);

  always #4 clk_i = ~clk_i;

  // cipher model state
  logic [1:0]  key_size_q = aes_pkg::Key128;
  logic [63:0] key_q [4] = '{default: '0};
  logic [7:0]  sbox_t [256];
  logic [7:0]  isbox_t [256];

  blk_t pending_blocks[$];
  ct_t  expected_blocks[$];
  int   errors = 0;
  int   idle_gap = 0;
  bit   quiet = 0;
  bit   stim_done = 0;
  int   watch = 0;

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xt(a);
    end
    return acc;
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {sbox_t[w[31:24]], sbox_t[w[23:16]], sbox_t[w[15:8]], sbox_t[w[7:0]]};
  endfunction

  // AES transform of one block with the current key registers
  function automatic ct_t aes_transform(input blk_t b);
    logic [31:0] w [60];
    logic [7:0]  s [16];
    logic [7:0]  o [16];
    logic [7:0]  m [4];
    logic [7:0]  rc [11];
    logic [31:0] t;
    logic [63:0] k;
    int nk, nr, rr, src;
    ct_t res;
    rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
    nk = (key_size_q == aes_pkg::Key128) ? 4 : (key_size_q == aes_pkg::Key192) ? 6 : 8;
    nr = nk + 6;
    for (int i = 0; i < nk; i++) begin
      k = key_q[i / 2];
      w[i] = (i % 2) ? k[31:0] : k[63:32];
    end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i - 1];
      if (i % nk == 0) t = subw({t[23:0], t[31:24]}) ^ {rc[i / nk], 24'h0};
      else if (nk > 6 && i % nk == 4) t = subw(t);
      w[i] = w[i - nk] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = b.hi[63 - 8 * i -: 8];
      s[8 + i] = b.lo[63 - 8 * i -: 8];
    end
    for (int step = 0; step <= nr; step++) begin
      rr = (b.op == OpEncrypt) ? step : nr - step;
      if (step > 0) begin
        // shift rows, then substitute
        o = s;
        for (int r = 1; r < 4; r++)
          for (int c = 0; c < 4; c++) begin
            src = (b.op == OpDecrypt) ? (c - r + 4) % 4 : (c + r) % 4;
            s[r + 4 * c] = o[r + 4 * src];
          end
        for (int i = 0; i < 16; i++)
          s[i] = (b.op == OpEncrypt) ? sbox_t[s[i]] : isbox_t[s[i]];
        // forward mix sits before the key add
        if (b.op == OpEncrypt && step < nr)
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) m[r] = s[4 * c + r];
            for (int r = 0; r < 4; r++)
              s[4 * c + r] = gmul(m[r], 8'd2) ^ gmul(m[(r + 1) % 4], 8'd3)
                           ^ m[(r + 2) % 4] ^ m[(r + 3) % 4];
          end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[4 * rr + c][31 - 8 * r -: 8];
      // inverse mix follows the key add
      if (b.op == OpDecrypt && step > 0 && step < nr)
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) m[r] = s[4 * c + r];
          for (int r = 0; r < 4; r++)
            s[4 * c + r] = gmul(m[r], 8'd14) ^ gmul(m[(r + 1) % 4], 8'd11)
                         ^ gmul(m[(r + 2) % 4], 8'd13) ^ gmul(m[(r + 3) % 4], 8'd9);
        end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8 * i -: 8] = s[i];
      res.lo[63 - 8 * i -: 8] = s[8 + i];
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %016h want %016h at %0t", what, got, want, $realtime);
  endtask

  // driver: one transfer per accepted start
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_blocks.push_back(aes_transform('{op_e'(kind_i), block_high_i, block_low_i}));
        void'(pending_blocks.pop_front());
      end
      if (start_i && !busy_o || !start_i) begin
        if (idle_gap > 0) begin
          idle_gap <= idle_gap - 1;
          start_i <= 1'b0;
        end else if (pending_blocks.size() > 0 && !quiet) begin
          if (!stim_done && $urandom_range(0, 5) == 0) begin
            idle_gap <= $urandom_range(1, 6);
            start_i <= 1'b0;
          end else begin
            blk_t nb;
            nb = pending_blocks[0];
            start_i <= 1'b1;
            kind_i <= nb.op;
            block_high_i <= nb.hi;
            block_low_i <= nb.lo;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every done strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      watch <= (done_o || (start_i && !busy_o)) ? 0 : watch + 1;
      if (done_o) begin
        if (expected_blocks.size() == 0) begin
          report("unexpected result", result_high_o, 64'h0);
        end else begin
          ct_t e;
          e = expected_blocks.pop_front();
          if (result_high_o !== e.hi) report("result_high", result_high_o, e.hi);
          if (result_low_o !== e.lo) report("result_low", result_low_o, e.lo);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (watch >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || start_i || expected_blocks.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == aes_pkg::CfgKeySize) key_size_q = val[1:0];
    else key_q[idx - aes_pkg::CfgKey0] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(aes_pkg::CfgKeySize, {62'b0, ks});
    write_reg(aes_pkg::CfgKey0, k0);
    write_reg(aes_pkg::CfgKey0 + 3'd1, k1);
    write_reg(aes_pkg::CfgKey0 + 3'd2, k2);
    write_reg(aes_pkg::CfgKey3, k3);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_block(input op_e op, input logic [63:0] hi, input logic [63:0] lo);
    pending_blocks.push_back('{op, hi, lo});
  endtask

  initial begin
    logic [1:0] ks;
    rst_ni <= 1'b0;
    sbox_t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    for (int i = 0; i < 256; i++) isbox_t[sbox_t[i]] = i[7:0];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset key (all zero, AES-128), then known vectors, edge blocks
    queue_block(OpEncrypt, '0, '0);
    queue_block(OpDecrypt, '1, '1);
    wait_drained();
    load_key(aes_pkg::Key128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    queue_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    wait_drained();
    load_key(aes_pkg::Key192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    queue_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OpDecrypt, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    wait_drained();
    load_key(aes_pkg::Key256, '1, '1, '1, '1);
    queue_block(OpEncrypt, '1, '0);
    queue_block(OpDecrypt, '0, '1);
    wait_drained();
    // unused key size code behaves as a 256-bit key
    load_key(2'd3, 64'h8000000000000001, 64'h0123456789abcdef, '0, 64'hfedcba9876543210);
    queue_block(OpEncrypt, 64'h8000000000000000, 64'h1);
    queue_block(OpDecrypt, 64'h1, 64'h8000000000000000);
    wait_drained();

    // random phases, fresh keys after the first; sender pauses fully between phases
    for (int ph = 0; ph < 24; ph++) begin
      ks = (ph % 4 == 3) ? 2'($urandom_range(0, 3)) : 2'(ph % 3);
      if (ph == 0) write_reg(aes_pkg::CfgKeySize, {62'b0, aes_pkg::Key128});
      else load_key(ks, rnd64(), rnd64(), rnd64(), rnd64());
      if (ph == 23) stim_done = 1;
      for (int n = 0; n < 48; n++)
        queue_block(op_e'($urandom_range(0, 1)), rnd64(), rnd64());
      if (ph == 10) begin
        quiet = 1;
        while (expected_blocks.size() != 0 || start_i) @(posedge clk_i);
        quiet = 0;
      end
      wait_drained();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
